// File: rtl/core/dcsc_pkg.sv
// ----------------------------------------------------------------------------
// dcsc_pkg: shared types and constants of the double-click selection cycler
// Request and result payloads, configuration and state records, event codes,
// register indexes and potentiometer command bytes.
// ----------------------------------------------------------------------------
`default_nettype none

package dcsc_pkg;

	localparam int unsigned NUM_SELECTIONS_DEF = 5;
	localparam int unsigned NUM_ENTRIES = 5;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	// Event codes carried in the action field.
	localparam logic [1:0] ACT_TICK    = 2'd0;
	localparam logic [1:0] ACT_PIN     = 2'd1;
	localparam logic [1:0] ACT_RESTORE = 2'd2;

	// Register indexes, byte address divided by four.
	localparam logic [2:0] REG_TICK_STEP = 3'd0;
	localparam logic [2:0] REG_TIMEOUT   = 3'd1;
	localparam logic [2:0] REG_DC_WINDOW = 3'd2;
	localparam logic [2:0] REG_ENTRY0    = 3'd3;
	localparam logic [2:0] REG_ENTRY1    = 3'd4;
	localparam logic [2:0] REG_ENTRY2    = 3'd5;
	localparam logic [2:0] REG_ENTRY3    = 3'd6;
	localparam logic [2:0] REG_ENTRY4    = 3'd7;

	localparam logic [7:0] CMD_POT_WRITE    = 8'h11;
	localparam logic [7:0] CMD_POT_SHUTDOWN = 8'h21;

	localparam logic [8:0]  TICK_STEP_RST = 9'd16;
	localparam logic [12:0] TIMEOUT_RST   = 13'd2000;
	localparam logic [12:0] DC_WINDOW_RST = 13'd200;
	localparam logic [15:0] ENTRY0_RST    = 16'h402B;
	localparam logic [15:0] ENTRY1_RST    = 16'h204C;
	localparam logic [15:0] ENTRY2_RST    = 16'h10A1;
	localparam logic [15:0] ENTRY3_RST    = 16'h08E0;
	localparam logic [15:0] ENTRY4_RST    = 16'h0400;

	typedef struct packed {
		logic [1:0] action;
		logic       pin_level;
		logic [2:0] restore_index;
	} req_t;

	typedef struct packed {
		logic [7:0] pot_command;
		logic [7:0] pot_value;
		logic [7:0] led_pattern;
		logic [2:0] chosen_index;
	} rsp_t;

	typedef struct packed {
		logic [8:0]                   tick_step_ms;
		logic [12:0]                  timeout_ms;
		logic [12:0]                  dc_window_ms;
		logic [NUM_ENTRIES-1:0][15:0] entry;
	} cfg_t;

	typedef struct packed {
		logic        timer_armed;
		logic [15:0] elapsed_ms;
		logic [15:0] last_low_ms;
		logic [2:0]  active_index;
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/dcsc_event_logic.sv
// ----------------------------------------------------------------------------
// dcsc_event_logic: next state and result for one event
// Combinational update of the timer and selection state for a single request.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsc_event_logic #(
	parameter int unsigned NUM_SELECTIONS = dcsc_pkg::NUM_SELECTIONS_DEF
) (
	input  wire dcsc_pkg::cfg_t   cfg,
	input  wire dcsc_pkg::state_t state_cur,
	input  wire dcsc_pkg::req_t   req,
	output dcsc_pkg::state_t      state_nxt,
	output logic                  rsp_valid,
	output dcsc_pkg::rsp_t        rsp
);

	logic [16:0] tick_sum;
	logic [15:0] tick_sat;
	logic [15:0] last_low;
	logic [15:0] gap;
	logic        double_click;
	logic [2:0]  next_index;
	logic [2:0]  sel_raw;
	logic [2:0]  sel;
	logic [15:0] entry;

	always_comb begin
		tick_sum = {1'b0, state_cur.elapsed_ms} + {8'd0, cfg.tick_step_ms};
		tick_sat = tick_sum[16] ? 16'hFFFF : tick_sum[15:0];

		// Arming clears the last-low time; a low level then records the current time.
		last_low = state_cur.timer_armed ? state_cur.last_low_ms : 16'd0;
		if (!req.pin_level) begin
			last_low = state_cur.elapsed_ms;
		end
		gap = state_cur.elapsed_ms - last_low;
		double_click = (last_low != 16'd0) && (state_cur.elapsed_ms > last_low)
			&& (gap <= {3'd0, cfg.dc_window_ms});

		next_index = state_cur.active_index + 3'd1;
		if (next_index >= 3'(NUM_SELECTIONS)) begin
			next_index = 3'd0;
		end

		state_nxt = state_cur;
		rsp_valid = 1'b0;
		sel_raw   = next_index;
		case (req.action)
			dcsc_pkg::ACT_TICK: begin
				if (state_cur.timer_armed) begin
					state_nxt.elapsed_ms = tick_sat;
					if (tick_sat >= {3'd0, cfg.timeout_ms}) begin
						state_nxt.timer_armed = 1'b0;
						state_nxt.elapsed_ms  = 16'd0;
					end
				end
			end
			dcsc_pkg::ACT_PIN: begin
				state_nxt.timer_armed = 1'b1;
				state_nxt.last_low_ms = last_low;
				if (double_click) begin
					state_nxt.timer_armed = 1'b0;
					state_nxt.elapsed_ms  = 16'd0;
					rsp_valid = req.pin_level;
				end
			end
			dcsc_pkg::ACT_RESTORE: begin
				sel_raw   = req.restore_index;
				rsp_valid = 1'b1;
			end
			default: begin
			end
		endcase

		sel = (sel_raw >= 3'(NUM_SELECTIONS)) ? 3'd0 : sel_raw;
		entry = cfg.entry[sel];
		if (rsp_valid) begin
			state_nxt.active_index = sel;
		end

		rsp.led_pattern  = entry[15:8];
		rsp.chosen_index = sel;
		if (entry[7:0] == 8'd0) begin
			rsp.pot_command = dcsc_pkg::CMD_POT_SHUTDOWN;
			rsp.pot_value   = 8'd0;
		end else begin
			rsp.pot_command = dcsc_pkg::CMD_POT_WRITE;
			rsp.pot_value   = entry[7:0];
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/double_click_selection_cycler.sv
// A request is held in the request register until the result register can take its
// result. Throughput: one request per cycle while the result channel is not stalled;
// the event logic sits between the two registers and the timer state updates in the same cycle.
// Reset: arst_n clears the timer, the selection and all valid flags at once, and
// loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// double_click_selection_cycler: button double-click selection cycler
// Tracks a button through tick, pin-change and restore requests, advances a
// selection on a double click and emits the potentiometer and LED settings.
// ----------------------------------------------------------------------------
`default_nettype none

module double_click_selection_cycler #(
	parameter int unsigned NUM_SELECTIONS = dcsc_pkg::NUM_SELECTIONS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Request channel.
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire dcsc_pkg::req_t          in_req,
	// Result channel.
	output logic                         out_valid,
	input  wire                          out_stall,
	output dcsc_pkg::rsp_t               out_rsp,
	// Configuration port.
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [dcsc_pkg::ADDR_W-1:0]   paddr,
	input  wire [dcsc_pkg::DATA_W-1:0]   pwdata,
	output logic [dcsc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	dcsc_pkg::cfg_t   cfg_q;
	dcsc_pkg::state_t state_q;
	dcsc_pkg::state_t state_nxt;
	dcsc_pkg::req_t   req_s1;
	logic             vld_s1;
	dcsc_pkg::rsp_t   rsp_q;
	logic             rsp_vld_q;
	dcsc_pkg::rsp_t   rsp_nxt;
	logic             rsp_nxt_vld;
	logic             out_ready;
	logic             fire;
	logic [2:0]       reg_idx;
	logic             cfg_wr;

	// The result register can take a new result when it is empty or being taken
	// this cycle. The request in stage one is processed exactly when that holds,
	// so the request register refills in the same cycle and no bubble appears.
	assign out_ready = !rsp_vld_q || !out_stall;
	assign fire      = vld_s1 && out_ready;
	assign in_stall  = vld_s1 && !out_ready;

	assign out_valid = rsp_vld_q;
	assign out_rsp   = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_req;
		end
	end

	dcsc_event_logic #(
		.NUM_SELECTIONS(NUM_SELECTIONS)
	) u_event_logic (
		.cfg       (cfg_q),
		.state_cur (state_q),
		.req       (req_s1),
		.state_nxt (state_nxt),
		.rsp_valid (rsp_nxt_vld),
		.rsp       (rsp_nxt)
	);

	// State advances only when the request in stage one is actually consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			rsp_vld_q <= 1'b0;
		end else if (out_ready) begin
			rsp_vld_q <= fire && rsp_nxt_vld;
			if (fire) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && rsp_nxt_vld) begin
			rsp_q <= rsp_nxt;
		end
	end

	// Configuration registers, one per 32-bit word. Writes land on the access phase;
	// software must write them only while the block is idle, which the block does not enforce.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_step_ms <= dcsc_pkg::TICK_STEP_RST;
			cfg_q.timeout_ms   <= dcsc_pkg::TIMEOUT_RST;
			cfg_q.dc_window_ms <= dcsc_pkg::DC_WINDOW_RST;
			cfg_q.entry[0]     <= dcsc_pkg::ENTRY0_RST;
			cfg_q.entry[1]     <= dcsc_pkg::ENTRY1_RST;
			cfg_q.entry[2]     <= dcsc_pkg::ENTRY2_RST;
			cfg_q.entry[3]     <= dcsc_pkg::ENTRY3_RST;
			cfg_q.entry[4]     <= dcsc_pkg::ENTRY4_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				dcsc_pkg::REG_TICK_STEP: cfg_q.tick_step_ms <= pwdata[8:0];
				dcsc_pkg::REG_TIMEOUT:   cfg_q.timeout_ms   <= pwdata[12:0];
				dcsc_pkg::REG_DC_WINDOW: cfg_q.dc_window_ms <= pwdata[12:0];
				dcsc_pkg::REG_ENTRY0:    cfg_q.entry[0]     <= pwdata[15:0];
				dcsc_pkg::REG_ENTRY1:    cfg_q.entry[1]     <= pwdata[15:0];
				dcsc_pkg::REG_ENTRY2:    cfg_q.entry[2]     <= pwdata[15:0];
				dcsc_pkg::REG_ENTRY3:    cfg_q.entry[3]     <= pwdata[15:0];
				dcsc_pkg::REG_ENTRY4:    cfg_q.entry[4]     <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dcsc_pkg::REG_TICK_STEP: prdata = {23'd0, cfg_q.tick_step_ms};
			dcsc_pkg::REG_TIMEOUT:   prdata = {19'd0, cfg_q.timeout_ms};
			dcsc_pkg::REG_DC_WINDOW: prdata = {19'd0, cfg_q.dc_window_ms};
			dcsc_pkg::REG_ENTRY0:    prdata = {16'd0, cfg_q.entry[0]};
			dcsc_pkg::REG_ENTRY1:    prdata = {16'd0, cfg_q.entry[1]};
			dcsc_pkg::REG_ENTRY2:    prdata = {16'd0, cfg_q.entry[2]};
			dcsc_pkg::REG_ENTRY3:    prdata = {16'd0, cfg_q.entry[3]};
			dcsc_pkg::REG_ENTRY4:    prdata = {16'd0, cfg_q.entry[4]};
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/dcsc_checker.sv
// ----------------------------------------------------------------------------
// dcsc_checker: port-level checks of the selection cycler
// Watches the request and result channels and flags illegal results.
// ----------------------------------------------------------------------------
`default_nettype none

module dcsc_checker #(
	parameter int unsigned NUM_SELECTIONS = dcsc_pkg::NUM_SELECTIONS_DEF
) (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input wire dcsc_pkg::rsp_t out_rsp
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_rsp))
		else $error("result changed while stalled");

	// A fresh result always traces back to an earlier accepted request.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted request");

	// Shutdown always goes out with zero data, a write never does.
	a_pot_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_rsp.pot_command == dcsc_pkg::CMD_POT_SHUTDOWN
			&& out_rsp.pot_value == 8'd0)
			|| (out_rsp.pot_command == dcsc_pkg::CMD_POT_WRITE
			&& out_rsp.pot_value != 8'd0))
		else $error("inconsistent potentiometer command");

	// The reported selection lies within the table.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_rsp.chosen_index < 3'(NUM_SELECTIONS))
		else $error("selection index out of range");

endmodule

bind double_click_selection_cycler dcsc_checker #(
	.NUM_SELECTIONS(NUM_SELECTIONS)
) u_dcsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_rsp   (out_rsp)
);

`default_nettype wire
